// File: design/carv_pkg.sv
// Shared types and constants for the comb/allpass reverb core.
package carv_pkg;
	localparam int NCOMB = 8;
	localparam int NAP = 4;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [15:0] FB_OFFSET = 16'd45875;
	localparam logic [14:0] FB_SCALE = 15'd19005;
	localparam logic [9:0] WET_GAIN = 10'd983;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CREAD, ST_CLP, ST_CMUL, ST_CWR,
		ST_AREAD, ST_AWR, ST_SQRT, ST_MIX1, ST_MIX2, ST_MIX3, ST_OUT, ST_CLEAR
	} state_t;

	function automatic int std_comb_len(input int i);
		case (i)
			0: return 1116;
			1: return 1188;
			2: return 1277;
			3: return 1356;
			4: return 1422;
			5: return 1491;
			6: return 1557;
			default: return 1617;
		endcase
	endfunction

	function automatic int std_ap_len(input int i);
		case (i)
			0: return 556;
			1: return 441;
			2: return 341;
			default: return 225;
		endcase
	endfunction

	function automatic int scale_len(input int std, input int rate, input int depth);
		longint n;
		begin
			n = (longint'(std) * rate + 22050) / 44100;
			if (n < 1) n = 1;
			if (n > depth) n = depth;
			return int'(n);
		end
	endfunction
endpackage

// File: design/carv_if.sv
// Valid/ready word channel.
interface carv_if #(parameter int W = 8) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/carv_ram.sv
// Generic single-port RAM with registered read.
module carv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: design/comb_allpass_reverb_core.sv
// Reverb core: 8 damped combs, 4 allpasses and a dry/wet mixer.
// One sample word at a time. A word walks the combs one after another, then
// the allpasses, then the two square roots and the mixing, then the output
// handoff; this order is set by the single shared delay-line port per memory.
// After reset both memories are cleared one entry a cycle, during which no
// word is accepted.
// in.data = {wet_mix, damping, room_size, sample_in}; out.data = {clipped, sample_out}.
module comb_allpass_reverb_core import carv_pkg::*; #(
	parameter int SAMPLE_RATE = 44100,
	parameter int COMB_LINE_DEPTH = 2048,
	parameter int ALLPASS_LINE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH = 24
) (
	input logic clk,
	input logic arst_n,
	carv_if.sink in,
	carv_if.source out
);
	localparam int CAW = $clog2(NCOMB * COMB_LINE_DEPTH);
	localparam int AAW = $clog2(NAP * ALLPASS_LINE_DEPTH);
	localparam int CPW = $clog2(COMB_LINE_DEPTH);
	localparam int APW = $clog2(ALLPASS_LINE_DEPTH);
	localparam int CW = SAMPLE_WIDTH;

	function automatic logic [CPW-1:0] clen(input logic [2:0] i);
		logic [CPW:0] l;
		begin
			l = '0;
			for (int k = 0; k < NCOMB; k++)
				if (i == k[2:0])
					l = (CPW+1)'(scale_len(std_comb_len(k), SAMPLE_RATE, COMB_LINE_DEPTH));
			return CPW'(l - 1'b1);
		end
	endfunction
	function automatic logic [APW-1:0] alen(input logic [1:0] i);
		logic [APW:0] l;
		begin
			l = '0;
			for (int k = 0; k < NAP; k++)
				if (i == k[1:0])
					l = (APW+1)'(scale_len(std_ap_len(k), SAMPLE_RATE, ALLPASS_LINE_DEPTH));
			return APW'(l - 1'b1);
		end
	endfunction
	function automatic logic [31:0] sat32(input logic signed [47:0] v, output logic c);
		begin
			c = (v > 48'sd2147483647) || (v < -48'sd2147483648);
			if (v > 48'sd2147483647) return 32'h7fffffff;
			if (v < -48'sd2147483648) return 32'h80000000;
			return v[31:0];
		end
	endfunction

	state_t state_q, state_d;
	logic [CAW-1:0] clr_q;
	logic [2:0] idx_q;
	logic [CPW-1:0] cpos_q [NCOMB];
	logic [APW-1:0] apos_q [NAP];
	logic signed [31:0] lp_q [NCOMB];
	logic signed [CW-1:0] dry_q;
	logic [16:0] fb_q, damp_q, mix_q;
	logic signed [35:0] t_q;
	logic signed [47:0] prod_q;
	logic clip_q;
	logic [4:0] sq_cnt_q;
	logic [33:0] sv_q, sr_q, sv2_q, sr2_q, sb_q;
	logic signed [63:0] acc_q;
	logic signed [CW-1:0] out_data_q;
	logic out_clip_q, out_valid_q;

	logic cwe, awe;
	logic [CAW-1:0] caddr;
	logic [AAW-1:0] aaddr;
	logic [31:0] cwd, awd, crd, ard;

	carv_ram #(.WIDTH(32), .DEPTH(NCOMB * COMB_LINE_DEPTH)) u_comb (
		.clk, .we(cwe), .addr(caddr), .wdata(cwd), .rdata(crd));
	carv_ram #(.WIDTH(32), .DEPTH(NAP * ALLPASS_LINE_DEPTH)) u_ap (
		.clk, .we(awe), .addr(aaddr), .wdata(awd), .rdata(ard));

	logic [16:0] sz_c, dp_c, mx_c;
	logic signed [47:0] lpdiff, cwr_v, awr_v;
	logic cclip, aclip;

	always_comb begin
		sz_c = (in.data[CW+16:CW] > ONE_Q16) ? ONE_Q16 : in.data[CW+16:CW];
		dp_c = (in.data[CW+33:CW+17] > ONE_Q16) ? ONE_Q16 : in.data[CW+33:CW+17];
		mx_c = (in.data[CW+50:CW+34] > ONE_Q16) ? ONE_Q16 : in.data[CW+50:CW+34];
		lpdiff = 48'(lp_q[idx_q]) - 48'(signed'(crd));
		cwr_v = (prod_q >>> 16) + 48'(dry_q);
		awr_v = 48'(signed'(ard) >>> 1) + 48'(t_q);
		cwd = sat32(cwr_v, cclip);
		awd = sat32(awr_v, aclip);
		cwe = 1'b0;
		awe = 1'b0;
		caddr = CAW'({idx_q, cpos_q[idx_q]});
		aaddr = AAW'({idx_q[1:0], apos_q[idx_q[1:0]]});
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cwe = 1'b1;
				awe = 1'b1;
				caddr = clr_q;
				aaddr = AAW'(clr_q);
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: if (in.valid && !out_valid_q) state_d = ST_CREAD;
			ST_CREAD: state_d = ST_CLP;
			ST_CLP: state_d = ST_CMUL;
			ST_CMUL: state_d = ST_CWR;
			ST_CWR: begin
				cwe = 1'b1;
				state_d = (idx_q == 3'(NCOMB - 1)) ? ST_AREAD : ST_CREAD;
			end
			ST_AREAD: state_d = ST_AWR;
			ST_AWR: begin
				awe = 1'b1;
				state_d = (idx_q == 3'(NAP - 1)) ? ST_SQRT : ST_AREAD;
			end
			ST_SQRT: if (sq_cnt_q == 5'd16) state_d = ST_MIX1;
			ST_MIX1: state_d = ST_MIX2;
			ST_MIX2: state_d = ST_MIX3;
			ST_MIX3: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_CLEAR) begin
			cwd = 32'd0;
			awd = 32'd0;
		end
	end

	assign in.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out.valid = out_valid_q;
	assign out.data = {out_clip_q, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// one isqrt step: two bits of radicand per cycle for both roots
	function automatic void sq_step(inout logic [33:0] v, inout logic [33:0] r,
		input logic [33:0] b);
		begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		logic [33:0] v1, r1, v2, r2;
		logic c;
		if (!arst_n) begin
			clr_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			clip_q <= 1'b0;
			sq_cnt_q <= '0;
			for (int i = 0; i < NCOMB; i++) begin
				cpos_q[i] <= '0;
				lp_q[i] <= '0;
			end
			for (int i = 0; i < NAP; i++) apos_q[i] <= '0;
		end else begin
			if (out.valid && out.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (in.valid && !out_valid_q) begin
					dry_q <= in.data[CW-1:0];
					fb_q <= 17'(FB_OFFSET) + 17'((32'(FB_SCALE) * sz_c + 32'd32768) >> 16);
					damp_q <= dp_c >> 1;
					mix_q <= mx_c;
					t_q <= '0;
					clip_q <= 1'b0;
					idx_q <= '0;
				end
				ST_CLP: begin
					t_q <= t_q + 36'(signed'(crd));
					// new lowpass straight from the word just read
					lp_q[idx_q] <= 32'(48'(signed'(crd))
						+ ((lpdiff * 48'(signed'({1'b0, damp_q}))) >>> 16));
				end
				ST_CMUL: begin
					// feedback product from the new lowpass value
					prod_q <= 48'(lp_q[idx_q]) * 48'(signed'({1'b0, fb_q}));
				end
				default: ;
			endcase
			if (state_q == ST_CWR) begin
				clip_q <= clip_q | cclip;
				cpos_q[idx_q] <= (cpos_q[idx_q] >= clen(idx_q)) ? '0 : cpos_q[idx_q] + 1'b1;
				idx_q <= (idx_q == 3'(NCOMB - 1)) ? '0 : idx_q + 1'b1;
			end
			if (state_q == ST_AWR) begin
				clip_q <= clip_q | aclip;
				t_q <= 36'(signed'(ard)) - t_q;
				apos_q[idx_q[1:0]] <= (apos_q[idx_q[1:0]] >= alen(idx_q[1:0])) ? '0
					: apos_q[idx_q[1:0]] + 1'b1;
				idx_q <= (idx_q == 3'(NAP - 1)) ? '0 : idx_q + 1'b1;
				sq_cnt_q <= '0;
				sv_q <= {1'b0, mix_q, 16'd0};
				sv2_q <= {1'b0, ONE_Q16 - mix_q, 16'd0};
				sr_q <= '0;
				sr2_q <= '0;
				sb_q <= 34'd1 << 32;
			end
			if (state_q == ST_SQRT) begin
				v1 = sv_q; r1 = sr_q; v2 = sv2_q; r2 = sr2_q;
				sq_step(v1, r1, sb_q);
				sq_step(v2, r2, sb_q);
				sv_q <= v1; sr_q <= r1; sv2_q <= v2; sr2_q <= r2;
				sb_q <= sb_q >> 2;
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (state_q == ST_MIX1) begin
				prod_q <= 48'(signed'({1'b0, WET_GAIN})) * 48'(signed'({1'b0, sr_q[16:0]}));
				acc_q <= 64'(dry_q) * 64'(signed'({1'b0, sr2_q[16:0]}));
			end
			if (state_q == ST_MIX2) begin
				acc_q <= (acc_q <<< 16) + 64'(t_q) * 64'(prod_q[27:0]) + (64'sd1 <<< 31);
			end
			if (state_q == ST_MIX3) begin
				acc_q <= acc_q >>> 32;
			end
			if (state_q == ST_OUT) begin
				c = (acc_q > 64'((64'sd1 <<< (CW - 1)) - 1)) || (acc_q < -(64'sd1 <<< (CW - 1)));
				if (acc_q > 64'((64'sd1 <<< (CW - 1)) - 1))
					out_data_q <= {1'b0, {(CW-1){1'b1}}};
				else if (acc_q < -(64'sd1 <<< (CW - 1)))
					out_data_q <= {1'b1, {(CW-1){1'b0}}};
				else
					out_data_q <= acc_q[CW-1:0];
				out_clip_q <= clip_q | c;
				out_valid_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready) |=> (state_q == ST_CREAD)) else $error("no start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid_q) else $error("no result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in.ready) else $error("overlap");
endmodule

// File: tb/sv/tb_comb_allpass_reverb_core.sv
// Testbench for the comb/allpass reverb core: random words checked against a local predictor.
module tb_comb_allpass_reverb_core;
	import carv_pkg::*;

	localparam int CDEPTH = 2048;
	localparam int ADEPTH = 1024;
	localparam int IN_W = 75;
	localparam int OUT_W = 25;
	localparam int QUIET_TAIL = 200;
	localparam int N_RANDOM = 1450;
	localparam int COMB_LEN [NCOMB] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_LEN [NAP] = '{556, 441, 341, 225};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	carv_if #(IN_W) in_ch (clk);
	carv_if #(OUT_W) out_ch (clk);

	comb_allpass_reverb_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	always #6 clk = ~clk;

	logic [IN_W-1:0] pending_words [$];
	logic [OUT_W-1:0] expected_words [$];
	int errors = 0;
	int results_seen = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 0;

	// predictor state
	int comb_mem [NCOMB][CDEPTH];
	int comb_lp [NCOMB];
	int comb_pos [NCOMB];
	int ap_mem [NAP][ADEPTH];
	int ap_pos [NAP];

	// no idling once the queue runs low
	function automatic bit calm();
		return pending_words.size() < QUIET_TAIL;
	endfunction

	function automatic longint clamp_q16(input logic [16:0] v);
		return (v > 17'd65536) ? 64'sd65536 : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int sat_word(input longint v, inout bit clip);
		if (v > 64'sd2147483647) begin
			clip = 1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			clip = 1;
			return 32'sh80000000;
		end
		return int'(v);
	endfunction

	function automatic logic [OUT_W-1:0] reverb_predict(input logic [IN_W-1:0] w);
		logic signed [23:0] s;
		longint dry, fb, t, y, lp, m1, m2, acc, o, size, damp, mix;
		bit clip;
		s = w[23:0];
		dry = s;
		size = clamp_q16(w[40:24]);
		damp = clamp_q16(w[57:41]) >>> 1;
		mix = clamp_q16(w[74:58]);
		fb = 45875 + ((19005 * size + 32768) >>> 16);
		clip = 0;
		t = 0;
		for (int i = 0; i < NCOMB; i++) begin
			y = comb_mem[i][comb_pos[i]];
			t += y;
			lp = y + (((longint'(comb_lp[i]) - y) * damp) >>> 16);
			comb_lp[i] = int'(lp);
			comb_mem[i][comb_pos[i]] = sat_word(((lp * fb) >>> 16) + dry, clip);
			comb_pos[i] = (comb_pos[i] + 1 >= COMB_LEN[i]) ? 0 : comb_pos[i] + 1;
		end
		for (int i = 0; i < NAP; i++) begin
			y = ap_mem[i][ap_pos[i]];
			ap_mem[i][ap_pos[i]] = sat_word((y >>> 1) + t, clip);
			t = y - t;
			ap_pos[i] = (ap_pos[i] + 1 >= AP_LEN[i]) ? 0 : ap_pos[i] + 1;
		end
		m1 = longint'(int_sqrt(longint'(mix) << 16));
		m2 = longint'(int_sqrt(longint'(65536 - mix) << 16));
		acc = t * (983 * m1) + dry * m2 * 65536 + (64'sd1 <<< 31);
		o = acc >>> 32;
		if (o > 64'sd8388607) begin
			o = 64'sd8388607;
			clip = 1;
		end
		if (o < -64'sd8388608) begin
			o = -64'sd8388608;
			clip = 1;
		end
		return {clip, o[23:0]};
	endfunction

	function automatic logic [IN_W-1:0] make_word(input int smp, input int size, input int damp,
			input int mix);
		logic [23:0] s;
		logic [16:0] a, b, c;
		s = smp[23:0];
		a = size[16:0];
		b = damp[16:0];
		c = mix[16:0];
		return {c, b, a, s};
	endfunction

	function automatic int rand_control();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(65536, 131071);
		return $urandom_range(0, 65536);
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			gap_left <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_ch.data <= pending_words.pop_front();
				in_ch.valid <= 1'b1;
				if (!calm() && $urandom_range(0, 4) == 0)
					gap_left <= $urandom_range(1, 6);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long hold-off on the output side so the core backs up
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && results_seen == 150) begin
			hold_left <= 600;
			hold_done <= 1;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm() && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= (hold_left == 0);
		end
	end

	// predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n && in_ch.valid && in_ch.ready)
			expected_words.push_back(reverb_predict(in_ch.data));
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", out_ch.data, '0);
			end else begin
				want = expected_words.pop_front();
				if (out_ch.data[23:0] !== want[23:0])
					report_mismatch("sample_out", out_ch.data, want);
				if (out_ch.data[24] !== want[24])
					report_mismatch("clipped", out_ch.data, want);
			end
			results_seen <= results_seen + 1;
		end
	end

	initial begin
		// extremes of every field, saturating controls, all-dry and all-wet
		pending_words.push_back(make_word(8388607, 0, 0, 0));
		pending_words.push_back(make_word(-8388608, 65536, 65536, 65536));
		pending_words.push_back(make_word(0, 131071, 131071, 131071));
		pending_words.push_back(make_word(-1, 65535, 1, 32768));
		pending_words.push_back(make_word(1, 65537, 65537, 65537));
		pending_words.push_back(make_word(8388607, 65536, 0, 65536));
		pending_words.push_back(make_word(-8388608, 0, 131071, 0));
		pending_words.push_back(make_word(12345, 98304, 40000, 1));
		pending_words.push_back(make_word(-4194304, 32768, 65535, 65535));
		pending_words.push_back(make_word(4194304, 1, 2, 131070));
		// loud run to push the delay words toward saturation
		for (int i = 0; i < 12; i++)
			pending_words.push_back(make_word(i[0] ? -8388608 : 8388607, 65536, 0, 65536));
		for (int i = 0; i < N_RANDOM; i++) begin
			int smp;
			case ($urandom_range(0, 7))
				0: smp = 8388607;
				1: smp = -8388608;
				default: smp = $urandom();
			endcase
			pending_words.push_back(make_word(smp, rand_control(), rand_control(),
				rand_control()));
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0);
		@(posedge clk);
		while (in_ch.valid) @(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#30000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
